FILE: src/olst_pkg.sv
package olst_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_SWAP   = 3'd3,
    OP_MOVE   = 3'd4,
    OP_DELETE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RA_A  = 2'd0,
    RA_B  = 2'd1,
    RA_RP = 2'd2
  } rd_addr_sel_t;

  typedef enum logic [1:0] {
    WA_CNT = 2'd0,
    WA_A   = 2'd1,
    WA_B   = 2'd2,
    WA_WP  = 2'd3
  } wr_addr_sel_t;

  typedef enum logic [1:0] {
    WD_VAL   = 2'd0,
    WD_RDATA = 2'd1,
    WD_TMP   = 2'd2
  } wr_data_sel_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
  } olst_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  count;
  } olst_out_t;

  typedef struct packed {
    logic         latch;
    logic         rd_en;
    rd_addr_sel_t rd_sel;
    logic         wr_en;
    wr_addr_sel_t wr_sel;
    wr_data_sel_t wd_sel;
    logic         tmp_ld;
    logic         shift_ld;
    logic         step_rd;
    logic         step_wr;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         resp;
    status_t      resp_status;
    logic         resp_rdata;
  } olst_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic a_ok;
    logic b_ok;
    logic same;
    logic del_last;
    logic shift_last;
  } olst_sts_t;

endpackage

FILE: src/ordered_list_store.sv
// Channel  Ports                    Handshake
// input    in_data                  taken when start is high and busy is low
// result   out_data                 one-cycle strobe on out_valid, never held off
//
// Read waits for the registered RAM output; swap reads both entries and writes
// each to the other's place; move and delete shift entries one by one (delete of
// the last entry only lowers the count). Shifts move one entry per cycle through the
// single write port of the entry RAM. The result strobe follows the last busy cycle.
// Reset clears the count and the controller; the entry RAM is not cleared.
// The receiver cannot stall; a new word may be started while a result is shown.
module ordered_list_store import olst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  olst_in_t  in_data,
  output logic      out_valid,
  output olst_out_t out_data
);

  olst_cmd_t cmd;
  olst_sts_t sts;

  olst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  olst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.count <= CNT_W'(CAPACITY)))
    else $error("count above capacity");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("word finished without a result");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in progress");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.read_value == '0))
    else $error("read value not zero on error");

  a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |-> (out_data.count == CNT_W'(CAPACITY)))
    else $error("full status below capacity");
`endif

endmodule

FILE: src/olst_ram.sv
module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/olst_ctrl.sv
module olst_ctrl import olst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  olst_sts_t sts,
  output logic      busy,
  output olst_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EXEC   = 10'b00_0000_0010,
    S_RDATA  = 10'b00_0000_0100,
    S_SWAP1  = 10'b00_0000_1000,
    S_SWAP2  = 10'b00_0001_0000,
    S_SWAP3  = 10'b00_0010_0000,
    S_MTMP   = 10'b00_0100_0000,
    S_PRIME  = 10'b00_1000_0000,
    S_SHIFT  = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        cmd.resp  = 1'b1;
        unique case (sts.op)
          OP_APPEND: begin
            if (sts.full) begin
              cmd.resp_status = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WA_CNT;
              cmd.wd_sel  = WD_VAL;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_READ: begin
            if (!sts.a_ok) begin
              cmd.resp_status = ST_RANGE;
            end else begin
              cmd.resp   = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_A;
              state_nxt  = S_RDATA;
            end
          end
          OP_WRITE: begin
            if (!sts.a_ok) begin
              cmd.resp_status = ST_RANGE;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WA_A;
              cmd.wd_sel = WD_VAL;
            end
          end
          OP_SWAP: begin
            if (!(sts.a_ok && sts.b_ok)) begin
              cmd.resp_status = ST_RANGE;
            end else begin
              cmd.resp   = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_A;
              state_nxt  = S_SWAP1;
            end
          end
          OP_MOVE: begin
            if (!(sts.a_ok && sts.b_ok)) begin
              cmd.resp_status = ST_RANGE;
            end else if (!sts.same) begin
              cmd.resp     = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RA_B;
              cmd.shift_ld = 1'b1;
              state_nxt    = S_MTMP;
            end
          end
          OP_DELETE: begin
            if (!sts.a_ok) begin
              cmd.resp_status = ST_RANGE;
            end else if (sts.del_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.resp     = 1'b0;
              cmd.shift_ld = 1'b1;
              state_nxt    = S_PRIME;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDATA: begin
        cmd.resp       = 1'b1;
        cmd.resp_rdata = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SWAP1: begin
        cmd.tmp_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_B;
        state_nxt  = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_A;
        cmd.wd_sel = WD_RDATA;
        state_nxt  = S_SWAP3;
      end
      S_SWAP3: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_B;
        cmd.wd_sel = WD_TMP;
        cmd.resp   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_MTMP: begin
        cmd.tmp_ld  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RA_RP;
        cmd.step_rd = 1'b1;
        state_nxt   = S_SHIFT;
      end
      S_PRIME: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RA_RP;
        cmd.step_rd = 1'b1;
        state_nxt   = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_WP;
        cmd.wd_sel = WD_RDATA;
        if (sts.shift_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_RP;
          cmd.step_rd = 1'b1;
          cmd.step_wr = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.op == OP_MOVE) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WA_A;
          cmd.wd_sel = WD_TMP;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/olst_dp.sv
module olst_dp import olst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  olst_in_t  in_data,
  input  olst_cmd_t cmd,
  output olst_sts_t sts,
  output logic      out_valid,
  output olst_out_t out_data
);

  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  ia_r;
  logic [IDX_W-1:0]  ib_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [DATA_W-1:0] tmp_r;
  logic [IDX_W-1:0]  wp_r;
  logic [IDX_W-1:0]  rp_r;
  logic [IDX_W-1:0]  lw_r;
  logic              up_r;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [DATA_W-1:0] rval_r;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic              move_up;

  olst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign move_up = (ia_r > ib_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RA_A:    ram_rd_addr = ia_r;
      RA_B:    ram_rd_addr = ib_r;
      RA_RP:   ram_rd_addr = rp_r;
      default: ram_rd_addr = rp_r;
    endcase
  end

  always_comb begin
    ram_wr_en = cmd.wr_en;
    unique case (cmd.wr_sel)
      WA_CNT:  ram_wr_addr = cnt_r[IDX_W-1:0];
      WA_A:    ram_wr_addr = ia_r;
      WA_B:    ram_wr_addr = ib_r;
      WA_WP:   ram_wr_addr = wp_r;
      default: ram_wr_addr = wp_r;
    endcase
    unique case (cmd.wd_sel)
      WD_VAL:   ram_wr_data = val_r;
      WD_RDATA: ram_wr_data = ram_rd_data;
      WD_TMP:   ram_wr_data = tmp_r;
      default:  ram_wr_data = val_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_data.operation;
      val_r <= in_data.value;
      ia_r  <= in_data.index_a;
      ib_r  <= in_data.index_b;
    end
    if (cmd.tmp_ld) begin
      tmp_r <= ram_rd_data;
    end
    if (cmd.resp) begin
      status_r <= cmd.resp_status;
      rval_r   <= cmd.resp_rdata ? ram_rd_data : '0;
    end
    if (cmd.shift_ld) begin
      if (op_r == OP_DELETE) begin
        up_r <= 1'b1;
        wp_r <= ia_r;
        rp_r <= ia_r + IDX_W'(1);
        lw_r <= cnt_r[IDX_W-1:0] - IDX_W'(2);
      end else begin
        up_r <= move_up;
        wp_r <= ib_r;
        rp_r <= move_up ? ib_r + IDX_W'(1) : ib_r - IDX_W'(1);
        lw_r <= move_up ? ia_r - IDX_W'(1) : ia_r + IDX_W'(1);
      end
    end else begin
      if (cmd.step_rd) begin
        rp_r <= up_r ? rp_r + IDX_W'(1) : rp_r - IDX_W'(1);
      end
      if (cmd.step_wr) begin
        wp_r <= up_r ? wp_r + IDX_W'(1) : wp_r - IDX_W'(1);
      end
    end
  end

  assign sts.op         = op_t'(op_r);
  assign sts.full       = (cnt_r == CNT_W'(CAPACITY));
  assign sts.a_ok       = ({1'b0, ia_r} < cnt_r);
  assign sts.b_ok       = ({1'b0, ib_r} < cnt_r);
  assign sts.same       = (ia_r == ib_r);
  assign sts.del_last   = (({1'b0, ia_r} + CNT_W'(1)) == cnt_r);
  assign sts.shift_last = (wp_r == lw_r);

  assign out_valid           = out_valid_r;
  assign out_data.status     = status_r;
  assign out_data.read_value = rval_r;
  assign out_data.count      = cnt_r;

endmodule

FILE: bench/ordered_list_store_tb.sv
`timescale 1ns / 100ps

module ordered_list_store_tb;
  import olst_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = CAPACITY + 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  olst_in_t  in_data;
  logic      out_valid;
  olst_out_t out_data;

  logic [DATA_W-1:0] mirror_entries [CAPACITY];
  int unsigned       mirror_count = 0;
  olst_out_t         awaited_results [$];
  int                idle_pct = 0;
  int                failures = 0;
  int                words_sent = 0;
  int                results_checked = 0;
  int                status_seen [3] = '{0, 0, 0};

  ordered_list_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic olst_out_t apply_to_mirror(olst_in_t w);
    olst_out_t         r;
    logic [DATA_W-1:0] held;
    int unsigned       a;
    int unsigned       b;
    logic              a_ok;
    logic              b_ok;
    r = '0;
    a = 32'(w.index_a);
    b = 32'(w.index_b);
    a_ok = a < mirror_count;
    b_ok = b < mirror_count;
    r.status = ST_OK;
    case (w.operation)
      OP_APPEND: begin
        if (mirror_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          mirror_entries[IDX_W'(mirror_count)] = w.value;
          mirror_count++;
        end
      end
      OP_READ: begin
        if (!a_ok) r.status = ST_RANGE;
        else r.read_value = mirror_entries[IDX_W'(a)];
      end
      OP_WRITE: begin
        if (!a_ok) r.status = ST_RANGE;
        else mirror_entries[IDX_W'(a)] = w.value;
      end
      OP_SWAP: begin
        if (!(a_ok && b_ok)) begin
          r.status = ST_RANGE;
        end else begin
          held = mirror_entries[IDX_W'(a)];
          mirror_entries[IDX_W'(a)] = mirror_entries[IDX_W'(b)];
          mirror_entries[IDX_W'(b)] = held;
        end
      end
      OP_MOVE: begin
        if (!(a_ok && b_ok)) begin
          r.status = ST_RANGE;
        end else if (a != b) begin
          held = mirror_entries[IDX_W'(b)];
          if (a > b) begin
            for (int i = b; i < a; i++) begin
              mirror_entries[IDX_W'(i)] = mirror_entries[IDX_W'(i + 1)];
            end
          end else begin
            for (int i = b; i > a; i--) begin
              mirror_entries[IDX_W'(i)] = mirror_entries[IDX_W'(i - 1)];
            end
          end
          mirror_entries[IDX_W'(a)] = held;
        end
      end
      OP_DELETE: begin
        if (!a_ok) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = a; i + 1 < mirror_count; i++) begin
            mirror_entries[IDX_W'(i)] = mirror_entries[IDX_W'(i + 1)];
          end
          mirror_count--;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(mirror_count);
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int hit_pct);
    if (mirror_count != 0 && $urandom_range(99) < hit_pct) begin
      return IDX_W'($urandom_range(mirror_count - 1));
    end
    return IDX_W'($urandom_range(CAPACITY - 1));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                           input logic [IDX_W-1:0] ia, input logic [IDX_W-1:0] ib);
    olst_in_t w;
    w.operation = op;
    w.value     = value;
    w.index_a   = ia;
    w.index_b   = ib;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_to_mirror(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    send_word(OP_READ, '0, 6'd0, 6'd0);
    send_word(OP_WRITE, 32'h1234_5678, 6'd0, 6'd0);
    send_word(OP_SWAP, '0, 6'd0, 6'd0);
    send_word(OP_MOVE, '0, 6'd0, 6'd0);
    send_word(OP_DELETE, '0, 6'd0, 6'd0);
    send_word(OP_SPARE_6, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_word(OP_APPEND, 32'h0000_0000, 6'd63, 6'd63);
    send_word(OP_APPEND, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_word(OP_APPEND, 32'hAAAA_AAAA, 6'd21, 6'd42);
    send_word(OP_APPEND, 32'h5555_5555, 6'd42, 6'd21);
    send_word(OP_READ, '0, 6'd1, 6'd0);
    send_word(OP_READ, '0, 6'd4, 6'd0);
    send_word(OP_READ, '0, 6'd63, 6'd0);
    send_word(OP_WRITE, 32'hDEAD_BEEF, 6'd2, 6'd0);
    send_word(OP_WRITE, 32'hCAFE_F00D, 6'd4, 6'd0);
    send_word(OP_SWAP, '0, 6'd0, 6'd3);
    send_word(OP_SWAP, '0, 6'd1, 6'd1);
    send_word(OP_SWAP, '0, 6'd0, 6'd4);
    send_word(OP_MOVE, '0, 6'd0, 6'd3);
    send_word(OP_MOVE, '0, 6'd3, 6'd0);
    send_word(OP_MOVE, '0, 6'd2, 6'd2);
    send_word(OP_MOVE, '0, 6'd1, 6'd5);
    send_word(OP_DELETE, '0, 6'd3, 6'd0);
    send_word(OP_DELETE, '0, 6'd0, 6'd0);
    send_word(OP_SPARE_7, 32'h8000_0001, 6'd1, 6'd2);
  endtask

  task automatic test_fill_to_capacity();
    idle_pct = 17;
    while (mirror_count < CAPACITY) begin
      send_word(OP_APPEND, $urandom(), pick_index(50), pick_index(50));
    end
    send_word(OP_APPEND, 32'h0BAD_0BAD, 6'd0, 6'd0);
    send_word(OP_APPEND, $urandom(), 6'd63, 6'd63);
    send_word(OP_READ, '0, 6'd63, 6'd0);
    send_word(OP_MOVE, '0, 6'd63, 6'd0);
    send_word(OP_MOVE, '0, 6'd0, 6'd63);
    send_word(OP_SWAP, '0, 6'd0, 6'd63);
    send_word(OP_WRITE, 32'hFFFF_FFFF, 6'd63, 6'd0);
    send_word(OP_READ, '0, 6'd0, 6'd0);
    send_word(OP_DELETE, '0, 6'd0, 6'd0);
    send_word(OP_APPEND, $urandom(), 6'd0, 6'd0);
    send_word(OP_DELETE, '0, 6'd63, 6'd0);
    send_word(OP_APPEND, $urandom(), 6'd0, 6'd0);
    send_word(OP_SPARE_6, $urandom(), 6'd0, 6'd0);
  endtask

  task automatic test_random_mix(input int n_words, input int idle);
    logic [OP_W-1:0] op;
    int              r;
    bit              grow;
    idle_pct = idle;
    grow = 1'b0;
    for (int k = 0; k < n_words; k++) begin
      if (k % 40 == 0) grow = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < (grow ? 35 : 8)) op = OP_APPEND;
      else if (r < 43) op = OP_DELETE;
      else if (r < 58) op = OP_READ;
      else if (r < 70) op = OP_WRITE;
      else if (r < 82) op = OP_SWAP;
      else if (r < 97) op = OP_MOVE;
      else op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
      send_word(op, $urandom(), pick_index(85), pick_index(85));
    end
  endtask

  task automatic test_drain_to_empty();
    idle_pct = 65;
    while (mirror_count != 0) begin
      if ($urandom_range(3) == 0) send_word(OP_READ, $urandom(), pick_index(90), pick_index(50));
      send_word(OP_DELETE, $urandom(), pick_index(100), pick_index(50));
    end
    send_word(OP_DELETE, '0, 6'd0, 6'd0);
    send_word(OP_READ, '0, 6'd0, 6'd0);
    send_word(OP_SWAP, '0, 6'd0, 6'd0);
    send_word(OP_MOVE, '0, 6'd63, 6'd63);
  endtask

  always @(posedge clk) begin : check_result
    olst_out_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with none outstanding: status %0d, read_value %h, count %0d",
               out_data.status, out_data.read_value, out_data.count);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
          failures++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          failures++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    wait_all_results();
    test_fill_to_capacity();
    wait_all_results();
    test_random_mix(100, 0);
    test_random_mix(100, 65);
    wait_all_results();
    test_random_mix(100, 17);
    test_drain_to_empty();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d results from %0d words: %0d ok, %0d out of range, %0d refused as full.",
             results_checked, words_sent, status_seen[ST_OK], status_seen[ST_RANGE],
             status_seen[ST_FULL]);
    $display("Covered empty to full and back with sender gaps of 0, 17 and 65 percent.");
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/olst_pkg.sv
src/olst_ram.sv
src/olst_ctrl.sv
src/olst_dp.sv
src/ordered_list_store.sv
bench/ordered_list_store_tb.sv
